@@ sv/cobsd_pkg.sv @@
// shared types and constants for the cobs stream decoder
`default_nettype none

package cobsd_pkg;

    localparam int unsigned MAX_FRAME   = 512;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [9:0] LIMIT_RESET = 10'd512;
    localparam logic [7:0] CODE_FULL   = 8'hFF;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [1:0] CAUSE_NONE  = 2'd0;
    localparam logic [1:0] CAUSE_ZERO  = 2'd1;
    localparam logic [1:0] CAUSE_TRUNC = 2'd2;
    localparam logic [1:0] CAUSE_OVF   = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [9:0] len;
        logic [1:0] cause;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } step_t;

endpackage

`default_nettype wire

@@ sv/cobsd_front.sv @@
// front end: frame state, byte classification and step building
`default_nettype none

module cobsd_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [9:0]        cfg_data,
    input  wire logic              accept,
    input  wire logic [7:0]        enc_byte,
    input  wire logic              frame_last,
    output logic                   step_valid,
    output cobsd_pkg::step_t       step
);

    localparam int unsigned LimCap =
        (cobsd_pkg::MAX_FRAME > 1023) ? 1023 : cobsd_pkg::MAX_FRAME;

    logic [9:0] limit_reg;
    logic [7:0] group_reg, group_next;
    logic       zero_reg, zero_next;
    logic [9:0] count_reg, count_next;
    logic       disc_reg, disc_next;

    logic [9:0] lim;
    logic       over;
    logic       emit_a, emit_b, failed, clr;
    logic [7:0] val_a;
    logic [1:0] kind_b, cause_b;
    cobsd_pkg::result_t res_a, res_b;

    assign lim  = (limit_reg > 10'(LimCap)) ? 10'(LimCap) : limit_reg;
    assign over = (count_reg >= lim);

    always_comb
    begin
        emit_a     = 1'b0;
        val_a      = 8'd0;
        emit_b     = 1'b0;
        kind_b     = cobsd_pkg::KIND_ERR;
        cause_b    = cobsd_pkg::CAUSE_NONE;
        failed     = 1'b0;
        clr        = 1'b0;
        group_next = group_reg;
        zero_next  = zero_reg;
        count_next = count_reg;
        disc_next  = disc_reg;
        if (disc_reg)
        begin
            clr = frame_last;
        end
        else
        begin
            if (group_reg == 8'd0)
            begin
                if (zero_reg)
                begin
                    zero_next = 1'b0;
                    if (over)
                    begin
                        failed  = 1'b1;
                        cause_b = cobsd_pkg::CAUSE_OVF;
                    end
                    else
                    begin
                        emit_a     = 1'b1;
                        count_next = count_reg + 10'd1;
                    end
                end
                if (!failed)
                begin
                    if (enc_byte == 8'd0)
                    begin
                        failed  = 1'b1;
                        cause_b = cobsd_pkg::CAUSE_ZERO;
                    end
                    else
                    begin
                        group_next = enc_byte - 8'd1;
                        zero_next  = (enc_byte != cobsd_pkg::CODE_FULL);
                    end
                end
            end
            else
            begin
                if (over)
                begin
                    failed  = 1'b1;
                    cause_b = cobsd_pkg::CAUSE_OVF;
                end
                else
                begin
                    emit_a     = 1'b1;
                    val_a      = enc_byte;
                    count_next = count_reg + 10'd1;
                    group_next = group_reg - 8'd1;
                end
            end
            if (failed)
            begin
                emit_b = 1'b1;
                if (frame_last)
                    clr = 1'b1;
                else
                    disc_next = 1'b1;
            end
            else if (frame_last)
            begin
                emit_b = 1'b1;
                clr    = 1'b1;
                if (group_next != 8'd0)
                    cause_b = cobsd_pkg::CAUSE_TRUNC;
                else
                    kind_b = cobsd_pkg::KIND_END;
            end
        end
        if (clr)
        begin
            group_next = 8'd0;
            zero_next  = 1'b0;
            disc_next  = 1'b0;
        end
    end

    always_comb
    begin
        res_a.kind  = cobsd_pkg::KIND_DATA;
        res_a.data  = val_a;
        res_a.len   = 10'd0;
        res_a.cause = cobsd_pkg::CAUSE_NONE;
        res_b.kind  = kind_b;
        res_b.data  = 8'd0;
        res_b.len   = (kind_b == cobsd_pkg::KIND_END) ? count_next : 10'd0;
        res_b.cause = cause_b;
    end

    assign step_valid = accept && (emit_a || emit_b);
    assign step.two   = emit_a && emit_b;
    assign step.r0    = emit_a ? res_a : res_b;
    assign step.r1    = res_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= cobsd_pkg::LIMIT_RESET;
            group_reg <= 8'd0;
            zero_reg  <= 1'b0;
            count_reg <= 10'd0;
            disc_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_data;
            if (accept)
            begin
                group_reg <= group_next;
                zero_reg  <= zero_next;
                count_reg <= clr ? 10'd0 : count_next;
                disc_reg  <= disc_next;
            end
        end
    end

    // a two-result step always leads with a decoded byte
    a_two_lead: assert property (@(posedge clk) disable iff (!rst_n)
        step_valid && step.two |-> step.r0.kind == cobsd_pkg::KIND_DATA)
        else $error("two-result step without leading data byte");

endmodule

`default_nettype wire

@@ sv/cobsd_queue.sv @@
// short step queue between front end and result sequencer
`default_nettype none

module cobsd_queue #(
    parameter int unsigned DEPTH = cobsd_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire cobsd_pkg::step_t  wr_data,
    output logic                   full,
    input  wire logic              rd_en,
    output cobsd_pkg::step_t       rd_data,
    output logic                   empty
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    cobsd_pkg::step_t mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_wr, do_rd;

    assign full    = (count_reg == CntW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        full && !do_rd |=> full)
        else $error("queue left full state without a read");

endmodule

`default_nettype wire

@@ sv/cobsd_back.sv @@
// result sequencer: hands out the one or two results of each queued step
`default_nettype none

module cobsd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cobsd_pkg::step_t  head,
    input  wire logic              q_empty,
    output logic                   q_rd,
    input  wire logic              pop,
    output logic                   empty,
    output logic [1:0]             kind,
    output logic [7:0]             data_value,
    output logic [9:0]             frame_length,
    output logic [1:0]             error_cause,
    output logic                   last_of_step
);

    logic sel_reg, sel_next;
    logic take;
    cobsd_pkg::result_t cur;

    assign empty        = q_empty;
    assign cur          = sel_reg ? head.r1 : head.r0;
    assign kind         = cur.kind;
    assign data_value   = cur.data;
    assign frame_length = cur.len;
    assign error_cause  = cur.cause;
    assign last_of_step = sel_reg || !head.two;

    assign take     = pop && !q_empty;
    assign q_rd     = take && last_of_step;
    assign sel_next = take ? (head.two && !sel_reg) : sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else
            sel_reg <= sel_next;
    end

    // second half only exists while its two-result step is still at the head
    a_sel_head: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> !q_empty && head.two)
        else $error("second result selected without a two-result head");

endmodule

`default_nettype wire

@@ sv/cobs_stream_decoder_core.sv @@
// top level of the cobs stream decoder
//
// Input channel: enc_byte and frame_last are transferred at a rising edge with
// push high and full low, one encoded byte per transfer, frame delimiter
// already removed. Result channel: while empty is low the oldest result is on
// kind, data_value, frame_length, error_cause and last_of_step; it is
// transferred at a rising edge with pop high.
// cfg_we with cfg_data writes the output limit; write it only while idle.
// Throughput: one input byte per cycle while full is low. Each byte yields
// zero, one or two results; the result side hands out one result per cycle
// while pop is high, so a byte with two results holds its queue slot for two
// pops, and its results show once all older results have been popped.
// A stalled result side fills the step queue (QUEUE_DEPTH steps) and then
// raises full; while full is high no byte is taken, not even one that would
// yield no result.
// Reset clears the frame state and the queue and sets the limit to 512.
`default_nettype none

module cobs_stream_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = cobsd_pkg::QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [9:0] cfg_data,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] enc_byte,
    input  wire logic       frame_last,
    input  wire logic       pop,
    output logic            empty,
    output logic [1:0]      kind,
    output logic [7:0]      data_value,
    output logic [9:0]      frame_length,
    output logic [1:0]      error_cause,
    output logic            last_of_step
);

    logic             accept;
    logic             step_valid;
    cobsd_pkg::step_t step;
    cobsd_pkg::step_t head;
    logic             q_full, q_empty, q_rd;

    assign full   = q_full;
    assign accept = push && !q_full;

    cobsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .enc_byte   (enc_byte),
        .frame_last (frame_last),
        .step_valid (step_valid),
        .step       (step)
    );

    cobsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (step_valid),
        .wr_data (step),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (head),
        .empty   (q_empty)
    );

    cobsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .q_rd         (q_rd),
        .pop          (pop),
        .empty        (empty),
        .kind         (kind),
        .data_value   (data_value),
        .frame_length (frame_length),
        .error_cause  (error_cause),
        .last_of_step (last_of_step)
    );

endmodule

`default_nettype wire

@@ tb/cobs_decode_checker.sv @@
// checker for the cobs stream decoder: predicts the results of every byte transfer and compares
module cobs_decode_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [9:0] cfg_data,
    input  wire logic       push,
    input  wire logic       full,
    input  wire logic [7:0] enc_byte,
    input  wire logic       frame_last,
    input  wire logic       pop,
    input  wire logic       empty,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] data_value,
    input  wire logic [9:0] frame_length,
    input  wire logic [1:0] error_cause,
    input  wire logic       last_of_step,
    output int              fail_count,
    output int              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        cobsd_pkg::result_t res;
        logic               fin;
    } decoded_t;

    logic [9:0] limit_reg;
    logic [7:0] group_left;
    logic       zero_due;
    logic [9:0] decoded_count;
    logic       dropping;

    decoded_t   step_buf [2];
    int         step_n;
    decoded_t   decoded_q [$];
    decoded_t   want;
    int         fails;
    int         n_left;

    assign fail_count  = fails;
    assign outstanding = n_left;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fails++;
    endtask

    function automatic void add_result(input logic [1:0] k, input logic [7:0] d,
                                       input logic [9:0] n, input logic [1:0] c);
        step_buf[step_n] = {k, d, n, c, 1'b0};
        step_n++;
    endfunction

    function automatic void clear_frame();
        group_left    = '0;
        zero_due      = 1'b0;
        decoded_count = '0;
        dropping      = 1'b0;
    endfunction

    function automatic void raise_error(input logic [1:0] c, input logic lst);
        add_result(cobsd_pkg::KIND_ERR, 8'd0, 10'd0, c);
        if (lst)
            clear_frame();
        else
            dropping = 1'b1;
    endfunction

    // returns 0 when the byte would exceed the limit
    function automatic logic emit_byte(input logic [7:0] v, input logic lst);
        logic [9:0] cap;
        cap = (limit_reg < 10'(cobsd_pkg::MAX_FRAME)) ? limit_reg
                                                      : 10'(cobsd_pkg::MAX_FRAME);
        if (decoded_count >= cap)
        begin
            raise_error(cobsd_pkg::CAUSE_OVF, lst);
            return 1'b0;
        end
        add_result(cobsd_pkg::KIND_DATA, v, 10'd0, cobsd_pkg::CAUSE_NONE);
        decoded_count++;
        return 1'b1;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic lst);
        logic ok;
        step_n = 0;
        ok     = 1'b1;
        if (dropping)
        begin
            if (lst)
                clear_frame();
        end
        else
        begin
            if (group_left == 0)
            begin
                if (zero_due)
                begin
                    zero_due = 1'b0;
                    ok       = emit_byte(8'd0, lst);
                end
                if (ok)
                begin
                    if (b == 8'd0)
                    begin
                        raise_error(cobsd_pkg::CAUSE_ZERO, lst);
                        ok = 1'b0;
                    end
                    else
                    begin
                        group_left = b - 8'd1;
                        zero_due   = (b != cobsd_pkg::CODE_FULL);
                    end
                end
            end
            else
            begin
                ok = emit_byte(b, lst);
                if (ok)
                    group_left--;
            end
            if (ok && lst)
            begin
                if (group_left != 0)
                    raise_error(cobsd_pkg::CAUSE_TRUNC, 1'b1);
                else
                begin
                    add_result(cobsd_pkg::KIND_END, 8'd0, decoded_count,
                               cobsd_pkg::CAUSE_NONE);
                    clear_frame();
                end
            end
        end
        if (step_n > 0)
            step_buf[step_n - 1].fin = 1'b1;
        for (int i = 0; i < step_n; i++)
            decoded_q.push_back(step_buf[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg = cobsd_pkg::LIMIT_RESET;
            clear_frame();
            decoded_q.delete();
            fails  = 0;
            n_left = 0;
        end
        else
        begin
            if (cfg_we)
                limit_reg = cfg_data;
            if (pop && !empty)
            begin
                if (decoded_q.size() == 0)
                    report_mismatch($sformatf("result transfer with nothing expected, kind %0d",
                                              kind));
                else
                begin
                    want = decoded_q.pop_front();
                    if (kind !== want.res.kind)
                        report_mismatch($sformatf("kind got %0d, expected %0d",
                                                  kind, want.res.kind));
                    if (data_value !== want.res.data)
                        report_mismatch($sformatf("data_value got %0h, expected %0h",
                                                  data_value, want.res.data));
                    if (frame_length !== want.res.len)
                        report_mismatch($sformatf("frame_length got %0d, expected %0d",
                                                  frame_length, want.res.len));
                    if (error_cause !== want.res.cause)
                        report_mismatch($sformatf("error_cause got %0d, expected %0d",
                                                  error_cause, want.res.cause));
                    if (last_of_step !== want.fin)
                        report_mismatch($sformatf("last_of_step got %0d, expected %0d",
                                                  last_of_step, want.fin));
                end
            end
            if (push && !full)
                decode_byte(enc_byte, frame_last);
            n_left = decoded_q.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// top of the cobs stream decoder testbench: clock, reset, frame stimulus and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 850;
    localparam int SEGMENTS     = 6;
    localparam int FRAME_MARGIN = 70;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 2 * cobsd_pkg::QUEUE_DEPTH + 4;
    localparam logic [9:0] SEG_LIMIT [SEGMENTS] =
        '{10'd1023, 10'd7, 10'd512, 10'd0, 10'd40, 10'd300};

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_we     = 1'b0;
    logic [9:0] cfg_data   = '0;
    logic       push       = 1'b0;
    logic [7:0] enc_byte   = '0;
    logic       frame_last = 1'b0;
    logic       pop        = 1'b0;
    logic       full;
    logic       empty;
    logic [1:0] kind;
    logic [7:0] data_value;
    logic [9:0] frame_length;
    logic [1:0] error_cause;
    logic       last_of_step;

    int fail_count;
    int outstanding;
    int tx_idle_pct = 28;
    int rx_idle_pct = 66;
    int sent        = 0;
    int cycles      = 0;

    cobs_stream_decoder_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .enc_byte     (enc_byte),
        .frame_last   (frame_last),
        .pop          (pop),
        .empty        (empty),
        .kind         (kind),
        .data_value   (data_value),
        .frame_length (frame_length),
        .error_cause  (error_cause),
        .last_of_step (last_of_step)
    );

    cobs_decode_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .enc_byte     (enc_byte),
        .frame_last   (frame_last),
        .pop          (pop),
        .empty        (empty),
        .kind         (kind),
        .data_value   (data_value),
        .frame_length (frame_length),
        .error_cause  (error_cause),
        .last_of_step (last_of_step),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("cobs_stream_decoder_core test failed");
            $finish;
        end
    end

    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= rx_idle_pct);

    task automatic transfer_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push       <= 1'b0;
            enc_byte   <= 8'($urandom);
            frame_last <= 1'($urandom);
            @(negedge clk);
        end
        push       <= 1'b1;
        enc_byte   <= b;
        frame_last <= lst;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // wait until every expected result has been transferred and the block is quiet
    task automatic settle();
        push <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input logic [9:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 2)
            return cobsd_pkg::CODE_FULL;
        else if (r < 6)
            return 8'($urandom_range(254, 13));
        return 8'($urandom_range(12, 1));
    endfunction

    function automatic logic [7:0] pick_literal();
        if ($urandom_range(15) == 0)
            return 8'd0;
        return 8'($urandom_range(255, 1));
    endfunction

    task automatic send_group(input logic [7:0] code, input logic closes);
        transfer_byte(code, closes && code == 8'd1);
        for (int i = 1; i < code; i++)
            transfer_byte(pick_literal(), closes && i == code - 1);
    endtask

    task automatic send_good_frame();
        int n;
        n = $urandom_range(4, 1);
        for (int g = 0; g < n; g++)
            send_group(pick_code(), g == n - 1);
    endtask

    task automatic send_bad_frame();
        int sel;
        int c;
        int k;
        sel = $urandom_range(2);
        case (sel)
            0:
            begin
                // group cut short by the frame end
                if ($urandom_range(1))
                    send_group(pick_code(), 1'b0);
                c = $urandom_range(20, 2);
                k = $urandom_range(c - 2);
                transfer_byte(8'(c), k == 0);
                for (int i = 0; i < k; i++)
                    transfer_byte(pick_literal(), i == k - 1);
            end
            1:
            begin
                // zero code byte, then up to four bytes to be dropped
                if ($urandom_range(1))
                    send_group(pick_code(), 1'b0);
                send_group(8'($urandom_range(8, 1)), 1'b0);
                k = $urandom_range(4);
                transfer_byte(8'd0, k == 0);
                for (int i = 0; i < k; i++)
                    transfer_byte(8'($urandom), i == k - 1);
            end
            default:
            begin
                k = $urandom_range(12, 1);
                for (int i = 0; i < k; i++)
                    transfer_byte(8'($urandom), i == k - 1 || $urandom_range(7) == 0);
            end
        endcase
    endtask

    initial
    begin
        int stop_at;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_limit(cobsd_pkg::LIMIT_RESET);
        transfer_byte(8'h01, 1'b1);
        transfer_byte(8'h00, 1'b1);
        transfer_byte(8'h03, 1'b0);
        transfer_byte(8'hAA, 1'b1);
        transfer_byte(8'h02, 1'b0);
        transfer_byte(8'h11, 1'b0);
        transfer_byte(8'h01, 1'b1);
        transfer_byte(8'h03, 1'b0);
        transfer_byte(8'hFF, 1'b0);
        transfer_byte(8'h00, 1'b0);
        transfer_byte(8'h00, 1'b0);
        transfer_byte(8'h33, 1'b1);
        settle();
        write_limit(10'd1);
        transfer_byte(8'h03, 1'b0);
        transfer_byte(8'h12, 1'b0);
        transfer_byte(8'h34, 1'b1);
        transfer_byte(8'h02, 1'b0);
        transfer_byte(8'h56, 1'b0);
        transfer_byte(8'h01, 1'b1);
        settle();
        write_limit(10'd0);
        transfer_byte(8'h01, 1'b1);
        transfer_byte(8'h02, 1'b0);
        transfer_byte(8'h9A, 1'b1);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            settle();
            write_limit(SEG_LIMIT[seg]);
            tx_idle_pct = (seg < 2) ? 28 : (seg < 4) ? 66 : 0;
            rx_idle_pct = (seg < 2) ? 66 : (seg < 4) ? 28 : 0;
            stop_at = sent + ITEM_TARGET / SEGMENTS;
            // leave room for the frame that runs past the mark
            while (sent + FRAME_MARGIN < stop_at)
            begin
                if ($urandom_range(9) < 7)
                    send_good_frame();
                else
                    send_bad_frame();
            end
        end

        settle();
        if (fail_count == 0)
            $display("cobs_stream_decoder_core test passed");
        else
            $display("cobs_stream_decoder_core test failed");
        $finish;
    end

endmodule

@@ files.f @@
sv/cobsd_pkg.sv
sv/cobsd_front.sv
sv/cobsd_queue.sv
sv/cobsd_back.sv
sv/cobs_stream_decoder_core.sv
tb/cobs_decode_checker.sv
tb/testbench.sv
